// ===== rtl/core/flr_pkg.sv =====
package flr_pkg;

   // Coordinate and fixed-point geometry
   localparam int COORD_BITS    = 12;
   localparam int FRACTION_BITS = 16;
   localparam int ACC_BITS      = 32;
   localparam int MINOR_BITS    = ACC_BITS - FRACTION_BITS;
   localparam int DIM_BITS      = 12;
   localparam int PROD_BITS     = 2 * DIM_BITS;
   localparam int OFFSET_BITS   = 22;
   localparam int COLOUR_BITS   = 8;
   localparam int WORD_BITS     = 4 * COLOUR_BITS;

   // Rounding seed for the minor accumulator: one half in 16.16
   localparam logic [ACC_BITS-1:0] HALF_LSB = ACC_BITS'(1) << (FRACTION_BITS - 1);

   // Slope divider: one quotient bit per cycle over the shifted minor delta
   localparam int DIV_STEPS      = COORD_BITS + FRACTION_BITS;
   localparam int DIV_COUNT_BITS = $clog2(DIV_STEPS);

   // Commands carried on the request channel
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_STEP  = 1'b1;

   // Register map
   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SCREEN_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SCREEN_HEIGHT = 1'b1;

   localparam logic [DIM_BITS-1:0] WIDTH_RESET  = DIM_BITS'(640);
   localparam logic [DIM_BITS-1:0] HEIGHT_RESET = DIM_BITS'(480);

   typedef struct packed {
      logic [COORD_BITS-1:0] x_start;
      logic [COORD_BITS-1:0] y_start;
      logic [COORD_BITS-1:0] x_end;
      logic [COORD_BITS-1:0] y_end;
      logic [WORD_BITS-1:0]  colour_word;
   } line_setup_type;

   typedef struct packed {
      logic setup;     // latch a start transaction, load the divider
      logic div_step;  // one restoring-division step
      logic div_last;  // final division step, write the slope
      logic pixel;     // emit the current pixel and advance
   } dp_cmd_type;

   typedef struct packed {
      logic line_active;
      logic rsp_busy;  // result register full and not taken this cycle
   } dp_status_type;

endpackage

// ===== rtl/core/flr_if.sv =====
interface flr_req_if;
   logic                                     valid;
   logic                                     ready;
   logic                                     cmd;
   logic [flr_pkg::COORD_BITS-1:0]           x_start;
   logic [flr_pkg::COORD_BITS-1:0]           y_start;
   logic [flr_pkg::COORD_BITS-1:0]           x_end;
   logic [flr_pkg::COORD_BITS-1:0]           y_end;
   logic [flr_pkg::COLOUR_BITS-1:0]          red;
   logic [flr_pkg::COLOUR_BITS-1:0]          green;
   logic [flr_pkg::COLOUR_BITS-1:0]          blue;
   logic [flr_pkg::COLOUR_BITS-1:0]          alpha;

   modport source (output valid, cmd, x_start, y_start, x_end, y_end, red, green, blue,
                   alpha, input ready);
   modport sink   (input valid, cmd, x_start, y_start, x_end, y_end, red, green, blue,
                   alpha, output ready);
endinterface

interface flr_rsp_if;
   logic                                     valid;
   logic                                     ready;
   logic [flr_pkg::COORD_BITS-1:0]           pixel_x;
   logic [flr_pkg::COORD_BITS-1:0]           pixel_y;
   logic [flr_pkg::OFFSET_BITS-1:0]          pixel_offset;
   logic                                     in_bounds;
   logic [flr_pkg::WORD_BITS-1:0]            pixel_word;
   logic                                     last;

   modport source (output valid, pixel_x, pixel_y, pixel_offset, in_bounds, pixel_word,
                   last, input ready);
   modport sink   (input valid, pixel_x, pixel_y, pixel_offset, in_bounds, pixel_word,
                   last, output ready);
endinterface

interface flr_csr_if;
   logic                                     valid;
   logic                                     ready;
   logic [flr_pkg::CSR_INDEX_BITS-1:0]       reg_index;
   logic [flr_pkg::DIM_BITS-1:0]             wdata;

   modport source (output valid, reg_index, wdata, input ready);
   modport sink   (input valid, reg_index, wdata, output ready);
endinterface

// ===== rtl/core/flr_ctrl.sv =====
module flr_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   flr_req_if.sink                req,
   input  flr_pkg::dp_status_type status,
   output flr_pkg::dp_cmd_type    cmd
);

   localparam logic ST_IDLE   = 1'b0;
   localparam logic ST_DIVIDE = 1'b1;

   logic                                state_ff;
   logic                                state_in;
   logic [flr_pkg::DIV_COUNT_BITS-1:0]  count_ff;
   logic [flr_pkg::DIV_COUNT_BITS-1:0]  count_in;
   logic                                accept;

   assign req.ready = (state_ff == ST_IDLE) && !status.rsp_busy;
   assign accept    = req.valid && req.ready;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req.cmd == flr_pkg::CMD_START) begin
                  cmd.setup = 1'b1;
                  state_in  = ST_DIVIDE;
                  count_in  = '0;
               end else begin
                  // a step with no line in progress is swallowed
                  cmd.pixel = status.line_active;
               end
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (count_ff == flr_pkg::DIV_COUNT_BITS'(flr_pkg::DIV_STEPS - 1)) begin
               cmd.div_last = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== rtl/core/flr_datapath.sv =====
module flr_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  flr_pkg::line_setup_type setup,
   input  flr_pkg::dp_cmd_type     cmd,
   output flr_pkg::dp_status_type  status,
   flr_rsp_if.source               rsp,
   flr_csr_if.sink                 csr
);

   localparam int CB = flr_pkg::COORD_BITS;
   localparam int MB = flr_pkg::MINOR_BITS;
   localparam int AB = flr_pkg::ACC_BITS;
   localparam int DB = flr_pkg::DIV_STEPS;

   // screen size registers
   logic [flr_pkg::DIM_BITS-1:0] width_ff, width_in;
   logic [flr_pkg::DIM_BITS-1:0] height_ff, height_in;

   // line state
   logic                         line_active_ff, line_active_in;
   logic                         major_y_ff, major_y_in;
   logic                         forward_ff, forward_in;
   logic [CB-1:0]                pos_ff, pos_in;
   logic [CB-1:0]                limit_ff, limit_in;
   logic [AB-1:0]                acc_ff, acc_in;
   logic [AB-1:0]                slope_ff, slope_in;
   logic [flr_pkg::WORD_BITS-1:0] colour_ff, colour_in;

   // divider
   logic [DB-1:0]                dvd_ff, dvd_in;
   logic [CB-1:0]                rem_ff, rem_in;
   logic [CB-1:0]                divisor_ff, divisor_in;
   logic                         neg_ff, neg_in;
   logic                         zero_ff, zero_in;

   // result register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [CB-1:0]                rsp_x_ff, rsp_x_in;
   logic [CB-1:0]                rsp_y_ff, rsp_y_in;
   logic [flr_pkg::OFFSET_BITS-1:0] rsp_offset_ff, rsp_offset_in;
   logic                         rsp_inside_ff, rsp_inside_in;
   logic [flr_pkg::WORD_BITS-1:0] rsp_word_ff, rsp_word_in;
   logic                         rsp_last_ff, rsp_last_in;

   // setup arithmetic
   logic [CB:0]                  dx, dy, dx_abs, dy_abs;
   logic                         take_y;
   logic [CB:0]                  short_d, long_d;
   logic [CB:0]                  short_abs, long_abs;
   logic [CB-1:0]                minor_start;

   // division step
   logic [CB:0]                  trial;
   logic                         trial_ge;
   logic [CB:0]                  trial_diff;
   logic [CB-1:0]                rem_next;
   logic [DB-1:0]                dvd_next;
   logic [AB-1:0]                quotient;

   // pixel arithmetic
   logic [MB-1:0]                minor_int;
   logic [MB-1:0]                major_ext;
   logic [MB-1:0]                px, py;
   logic                         on_screen;
   logic                         at_end;
   logic [flr_pkg::PROD_BITS-1:0] offset_sum;

   assign csr.ready = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr.valid) begin
         unique case (csr.reg_index)
            flr_pkg::REG_SCREEN_WIDTH:  width_in  = csr.wdata;
            flr_pkg::REG_SCREEN_HEIGHT: height_in = csr.wdata;
         endcase
      end
   end

   // endpoint deltas, axis choice
   always_comb begin
      dx          = {setup.x_end[CB-1], setup.x_end} - {setup.x_start[CB-1], setup.x_start};
      dy          = {setup.y_end[CB-1], setup.y_end} - {setup.y_start[CB-1], setup.y_start};
      dx_abs      = dx[CB] ? (~dx + 1'b1) : dx;
      dy_abs      = dy[CB] ? (~dy + 1'b1) : dy;
      take_y      = dy_abs > dx_abs;
      short_d     = take_y ? dx : dy;
      long_d      = take_y ? dy : dx;
      short_abs   = take_y ? dx_abs : dy_abs;
      long_abs    = take_y ? dy_abs : dx_abs;
      minor_start = take_y ? setup.x_start : setup.y_start;
   end

   // restoring division, one quotient bit per cycle
   always_comb begin
      trial      = {rem_ff, dvd_ff[DB-1]};
      trial_ge   = trial >= {1'b0, divisor_ff};
      trial_diff = trial - {1'b0, divisor_ff};
      rem_next   = trial_ge ? trial_diff[CB-1:0] : trial[CB-1:0];
      dvd_next   = {dvd_ff[DB-2:0], trial_ge};
      quotient   = AB'(dvd_next);
   end

   // current pixel from the line state
   always_comb begin
      minor_int  = acc_ff[AB-1 -: MB];
      major_ext  = {{(MB-CB){pos_ff[CB-1]}}, pos_ff};
      px         = major_y_ff ? minor_int : major_ext;
      py         = major_y_ff ? major_ext : minor_int;
      on_screen  = !px[MB-1] && !py[MB-1] &&
                   (px < MB'(width_ff)) && (py < MB'(height_ff));
      offset_sum = flr_pkg::PROD_BITS'(py[flr_pkg::DIM_BITS-1:0])
                 * flr_pkg::PROD_BITS'(width_ff)
                 + flr_pkg::PROD_BITS'(px[flr_pkg::DIM_BITS-1:0]);
      at_end     = pos_ff == limit_ff;
   end

   always_comb begin
      line_active_in = line_active_ff;
      major_y_in     = major_y_ff;
      forward_in     = forward_ff;
      pos_in         = pos_ff;
      limit_in       = limit_ff;
      acc_in         = acc_ff;
      slope_in       = slope_ff;
      colour_in      = colour_ff;
      dvd_in         = dvd_ff;
      rem_in         = rem_ff;
      divisor_in     = divisor_ff;
      neg_in         = neg_ff;
      zero_in        = zero_ff;

      rsp_valid_in   = rsp_valid_ff && !rsp.ready;
      rsp_x_in       = rsp_x_ff;
      rsp_y_in       = rsp_y_ff;
      rsp_offset_in  = rsp_offset_ff;
      rsp_inside_in  = rsp_inside_ff;
      rsp_word_in    = rsp_word_ff;
      rsp_last_in    = rsp_last_ff;

      if (cmd.setup) begin
         line_active_in = 1'b1;
         major_y_in     = take_y;
         forward_in     = !long_d[CB] && (long_d != '0);
         pos_in         = take_y ? setup.y_start : setup.x_start;
         limit_in       = take_y ? setup.y_end : setup.x_end;
         acc_in         = {{(MB-CB){minor_start[CB-1]}}, minor_start,
                           flr_pkg::FRACTION_BITS'(0)} + flr_pkg::HALF_LSB;
         colour_in      = setup.colour_word;
         dvd_in         = {short_abs[CB-1:0], flr_pkg::FRACTION_BITS'(0)};
         rem_in         = '0;
         divisor_in     = long_abs[CB-1:0];
         neg_in         = short_d[CB] ^ long_d[CB];
         zero_in        = long_abs == '0;
      end

      if (cmd.div_step) begin
         dvd_in = dvd_next;
         rem_in = rem_next;
      end

      if (cmd.div_last) begin
         priority if (zero_ff) begin
            slope_in = '0;
         end else if (neg_ff) begin
            slope_in = ~quotient + 1'b1;
         end else begin
            slope_in = quotient;
         end
      end

      if (cmd.pixel) begin
         rsp_valid_in  = 1'b1;
         rsp_x_in      = px[CB-1:0];
         rsp_y_in      = py[CB-1:0];
         rsp_offset_in = on_screen ? offset_sum[flr_pkg::OFFSET_BITS-1:0] : '0;
         rsp_inside_in = on_screen;
         rsp_word_in   = colour_ff;
         rsp_last_in   = at_end;
         priority if (at_end) begin
            line_active_in = 1'b0;
         end else if (forward_ff) begin
            pos_in = pos_ff + 1'b1;
            acc_in = acc_ff + slope_ff;
         end else begin
            pos_in = pos_ff - 1'b1;
            acc_in = acc_ff - slope_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff       <= flr_pkg::WIDTH_RESET;
         height_ff      <= flr_pkg::HEIGHT_RESET;
         line_active_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         width_ff       <= width_in;
         height_ff      <= height_in;
         line_active_ff <= line_active_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      major_y_ff    <= major_y_in;
      forward_ff    <= forward_in;
      pos_ff        <= pos_in;
      limit_ff      <= limit_in;
      acc_ff        <= acc_in;
      slope_ff      <= slope_in;
      colour_ff     <= colour_in;
      dvd_ff        <= dvd_in;
      rem_ff        <= rem_in;
      divisor_ff    <= divisor_in;
      neg_ff        <= neg_in;
      zero_ff       <= zero_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_inside_ff <= rsp_inside_in;
      rsp_word_ff   <= rsp_word_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign status.line_active = line_active_ff;
   assign status.rsp_busy    = rsp_valid_ff && !rsp.ready;

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.pixel_x      = rsp_x_ff;
   assign rsp.pixel_y      = rsp_y_ff;
   assign rsp.pixel_offset = rsp_offset_ff;
   assign rsp.in_bounds    = rsp_inside_ff;
   assign rsp.pixel_word   = rsp_word_ff;
   assign rsp.last         = rsp_last_ff;

endmodule

// ===== rtl/core/fixed_point_line_rasterizer_unit.sv =====
// Channel   Dir  Transaction contents
// --------  ---  --------------------------------------------------------------
// req_bus   in   cmd, x_start, y_start, x_end, y_end, red, green, blue, alpha
// rsp_bus   out  pixel_x, pixel_y, pixel_offset, in_bounds, pixel_word, last
// csr_bus   in   reg_index (0 screen_width, 1 screen_height), wdata
//
// A step transaction's pixel sits in the result register the next cycle,
// so steps stream at one per clock while rsp_bus keeps up.
// A start transaction runs the bit-serial slope divider, and req_bus.ready
// is low while it runs.
// A stalled result holds req_bus.ready low until it is taken.
// reset is synchronous; it clears the line and loads a 640 x 480 screen.
// csr_bus is always ready and takes effect on the following pixel.
module fixed_point_line_rasterizer_unit (
   input  logic       clock,
   input  logic       reset,
   flr_req_if.sink    req_bus,
   flr_rsp_if.source  rsp_bus,
   flr_csr_if.sink    csr_bus
);

   flr_pkg::line_setup_type setup;
   flr_pkg::dp_cmd_type     dp_cmd;
   flr_pkg::dp_status_type  dp_status;

   // endpoints plus ARGB packed high byte first
   always_comb begin
      setup.x_start     = req_bus.x_start;
      setup.y_start     = req_bus.y_start;
      setup.x_end       = req_bus.x_end;
      setup.y_end       = req_bus.y_end;
      setup.colour_word = {req_bus.alpha, req_bus.red, req_bus.green, req_bus.blue};
   end

   // sequencer: accepts transactions, runs the divider count
   flr_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .req    (req_bus),
      .status (dp_status),
      .cmd    (dp_cmd)
   );

   // line state, divider, pixel math, result register, screen registers
   flr_datapath u_datapath (
      .clock  (clock),
      .reset  (reset),
      .setup  (setup),
      .cmd    (dp_cmd),
      .status (dp_status),
      .rsp    (rsp_bus),
      .csr    (csr_bus)
   );

endmodule

// ===== rtl/core/flr_checker.sv =====
module flr_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                req_cmd,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [flr_pkg::COORD_BITS-1:0]      rsp_pixel_x,
   input logic [flr_pkg::COORD_BITS-1:0]      rsp_pixel_y,
   input logic [flr_pkg::OFFSET_BITS-1:0]     rsp_pixel_offset,
   input logic                                rsp_in_bounds
);

   // a start keeps the input closed while the slope is computed
   start_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_cmd == flr_pkg::CMD_START) |=> !req_ready)
      else $error("input open right after a start transaction");

   // a new result only ever follows an accepted step
   result_from_step: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_cmd == flr_pkg::CMD_STEP))
      else $error("result without an accepted step");

   // off-screen pixels carry a zero offset
   offscreen_offset: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_in_bounds) |-> (rsp_pixel_offset == '0))
      else $error("nonzero offset on off-screen pixel");

   stalled_result_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_pixel_x) && $stable(rsp_pixel_y)))
      else $error("stalled result changed");

endmodule

bind fixed_point_line_rasterizer_unit flr_checker u_flr_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_bus.valid),
   .req_ready        (req_bus.ready),
   .req_cmd          (req_bus.cmd),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_pixel_x      (rsp_bus.pixel_x),
   .rsp_pixel_y      (rsp_bus.pixel_y),
   .rsp_pixel_offset (rsp_bus.pixel_offset),
   .rsp_in_bounds    (rsp_bus.in_bounds)
);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import flr_pkg::*;

   // Coordinate range of the signed pixel fields
   localparam int COORD_MAX = (1 << (COORD_BITS - 1)) - 1;
   localparam int COORD_MIN = -(1 << (COORD_BITS - 1));
   // Longest line walked to its end; longer ones get abandoned part way
   localparam int MAX_WALK = 64;
   // Quiet time before a register write: covers a start still dividing
   localparam int DRAIN_CYCLES = DIV_STEPS + 8;
   localparam int SEGMENT_ITEMS = 250;
   localparam int HOLD_OFF_CYCLES = 400;

   // One request transaction, field order as on req_bus
   typedef struct packed {
      logic                   cmd;
      logic [COORD_BITS-1:0]  x_start;
      logic [COORD_BITS-1:0]  y_start;
      logic [COORD_BITS-1:0]  x_end;
      logic [COORD_BITS-1:0]  y_end;
      logic [COLOUR_BITS-1:0] red;
      logic [COLOUR_BITS-1:0] green;
      logic [COLOUR_BITS-1:0] blue;
      logic [COLOUR_BITS-1:0] alpha;
   } req_item_type;

   // One pixel transaction, field order as on rsp_bus
   typedef struct packed {
      logic [COORD_BITS-1:0]  pixel_x;
      logic [COORD_BITS-1:0]  pixel_y;
      logic [OFFSET_BITS-1:0] pixel_offset;
      logic                   in_bounds;
      logic [WORD_BITS-1:0]   pixel_word;
      logic                   last;
   } pixel_type;

   // Line walker mirror plus the queue of pixels still owed by the block
   class pixel_scoreboard;
      logic [DIM_BITS-1:0]   width;
      logic [DIM_BITS-1:0]   height;
      bit                    line_active;
      bit                    y_major;
      bit                    forward;
      logic [COORD_BITS-1:0] position;
      logic [COORD_BITS-1:0] limit;
      logic [ACC_BITS-1:0]   minor_acc;
      logic [ACC_BITS-1:0]   slope;
      logic [WORD_BITS-1:0]  colour;
      pixel_type             owed_pixels[$];
      int                    errors;

      function new();
         width = WIDTH_RESET;
         height = HEIGHT_RESET;
         line_active = 1'b0;
         y_major = 1'b0;
         forward = 1'b0;
         position = '0;
         limit = '0;
         minor_acc = '0;
         slope = '0;
         colour = '0;
         errors = 0;
      endfunction

      function void write_register(logic [CSR_INDEX_BITS-1:0] index, logic [DIM_BITS-1:0] value);
         if (index == REG_SCREEN_WIDTH) begin
            width = value;
         end else begin
            height = value;
         end
      endfunction

      function void note_request(req_item_type item);
         int        xs, ys, xe, ye;
         int        minor_len, major_len, minor_start, swap;
         int        minor, px, py;
         bit        on_screen;
         pixel_type pix;
         if (item.cmd == CMD_START) begin
            xs = $signed(item.x_start);
            ys = $signed(item.y_start);
            xe = $signed(item.x_end);
            ye = $signed(item.y_end);
            minor_len = ye - ys;
            major_len = xe - xs;
            minor_start = ys;
            y_major = 1'b0;
            position = item.x_start;
            limit = item.x_end;
            // strictly longer y extent makes y the major axis; ties stay on x
            if ((minor_len < 0 ? -minor_len : minor_len) >
                (major_len < 0 ? -major_len : major_len)) begin
               swap = minor_len;
               minor_len = major_len;
               major_len = swap;
               y_major = 1'b1;
               minor_start = xs;
               position = item.y_start;
               limit = item.y_end;
            end
            if (major_len != 0) begin
               slope = ACC_BITS'((minor_len * (1 << FRACTION_BITS)) / major_len);
            end else begin
               slope = '0;
            end
            minor_acc = (ACC_BITS'(minor_start) << FRACTION_BITS) + HALF_LSB;
            forward = major_len > 0;
            colour = {item.alpha, item.red, item.green, item.blue};
            line_active = 1'b1;
         end else if (line_active) begin
            minor = $signed(minor_acc) >>> FRACTION_BITS;
            if (y_major) begin
               px = minor;
               py = $signed(position);
            end else begin
               px = $signed(position);
               py = minor;
            end
            on_screen = px >= 0 && py >= 0 && px < int'(width) && py < int'(height);
            pix.pixel_x = COORD_BITS'(px);
            pix.pixel_y = COORD_BITS'(py);
            pix.pixel_offset = on_screen ? OFFSET_BITS'(py * int'(width) + px) : '0;
            pix.in_bounds = on_screen;
            pix.pixel_word = colour;
            pix.last = position == limit;
            owed_pixels.push_back(pix);
            if (pix.last) begin
               line_active = 1'b0;
            end else if (forward) begin
               position = position + 1'b1;
               minor_acc = minor_acc + slope;
            end else begin
               position = position - 1'b1;
               minor_acc = minor_acc - slope;
            end
         end
      endfunction

      function void compare(string name, logic [WORD_BITS-1:0] want, logic [WORD_BITS-1:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_pixel(pixel_type got);
         pixel_type want;
         if (owed_pixels.size() == 0) begin
            $display("%0t: pixel with nothing expected, expected none, got x=0x%0h y=0x%0h",
                     $time, got.pixel_x, got.pixel_y);
            errors++;
            return;
         end
         want = owed_pixels.pop_front();
         compare("pixel_x", want.pixel_x, got.pixel_x);
         compare("pixel_y", want.pixel_y, got.pixel_y);
         compare("pixel_offset", want.pixel_offset, got.pixel_offset);
         compare("in_bounds", want.in_bounds, got.in_bounds);
         compare("pixel_word", want.pixel_word, got.pixel_word);
         compare("last", want.last, got.last);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   flr_req_if req_bus ();
   flr_rsp_if rsp_bus ();
   flr_csr_if csr_bus ();

   fixed_point_line_rasterizer_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   pixel_scoreboard sb = new();

   // Idle odds in percent per cycle, and the receiver's long hold-off counter
   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   int rsp_hold_left = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Monitor: every transaction is taken at the rising edge it completes on.
   // Pixels are checked before the request of the same edge is noted; a pixel
   // can never come from a request accepted at that same edge anyway.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            sb.check_pixel({rsp_bus.pixel_x, rsp_bus.pixel_y, rsp_bus.pixel_offset,
                            rsp_bus.in_bounds, rsp_bus.pixel_word, rsp_bus.last});
         end
         if (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) begin
            sb.note_request({req_bus.cmd, req_bus.x_start, req_bus.y_start, req_bus.x_end,
                             req_bus.y_end, req_bus.red, req_bus.green, req_bus.blue,
                             req_bus.alpha});
         end
         if (csr_bus.valid === 1'b1 && csr_bus.ready === 1'b1) begin
            sb.write_register(csr_bus.reg_index, csr_bus.wdata);
         end
      end
   end

   // Receiver: random back-pressure, or a solid hold-off while the counter runs
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_left > 0) begin
            rsp_bus.ready = 1'b0;
            rsp_hold_left--;
         end else begin
            rsp_bus.ready = $urandom_range(99) >= rsp_idle_pct;
         end
      end
   end

   // Global watchdog
   initial begin
      #5_000_000;
      $display("fixed_point_line_rasterizer_unit regression: fail");
      $finish;
   end

   // Offer one request transaction. Called at a falling edge, returns at the
   // falling edge after acceptance with valid still high, so back-to-back
   // transactions drop valid in between only when the random idle odds say so.
   task automatic send_req(input req_item_type item);
      while ($urandom_range(99) < req_idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid = 1'b1;
      {req_bus.cmd, req_bus.x_start, req_bus.y_start, req_bus.x_end, req_bus.y_end,
       req_bus.red, req_bus.green, req_bus.blue, req_bus.alpha} = item;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [DIM_BITS-1:0] value);
      csr_bus.valid = 1'b1;
      csr_bus.reg_index = index;
      csr_bus.wdata = value;
      @(posedge clock);
      while (csr_bus.ready !== 1'b1) @(posedge clock);
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   // Stop offering, let every owed pixel out, then give a trailing start
   // time to finish its slope division.
   task automatic drain_pixels();
      req_bus.valid = 1'b0;
      while (sb.owed_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic req_item_type random_item(input logic cmd);
      req_item_type item;
      logic [95:0]  bits;
      bits = {$urandom, $urandom, $urandom};
      item = bits[$bits(req_item_type)-1:0];
      item.cmd = cmd;
      return item;
   endfunction

   function automatic logic [COORD_BITS-1:0] to_coord(input int v);
      if (v > COORD_MAX) begin
         v = COORD_MAX;
      end else if (v < COORD_MIN) begin
         v = COORD_MIN;
      end
      return COORD_BITS'(v);
   endfunction

   // Coordinate biased toward the screen edges and the origin
   function automatic int coord_near(input int edge_at);
      int v;
      case ($urandom_range(3))
         0: v = int'($urandom_range(4095)) + COORD_MIN;
         1: v = edge_at - 8 + int'($urandom_range(16));
         2: v = int'($urandom_range(16)) - 8;
         default: v = int'($urandom_range(edge_at));
      endcase
      return v;
   endfunction

   // Start transaction; span_len returns the number of major-axis steps
   function automatic req_item_type line_start(input bit wide, output int span_len);
      req_item_type item;
      int           x0, y0, reach, dx, dy;
      item = random_item(CMD_START);
      if (!wide) begin
         x0 = coord_near(int'(sb.width));
         y0 = coord_near(int'(sb.height));
         reach = ($urandom_range(9) == 0) ? 200 : 24;
         item.x_start = to_coord(x0);
         item.y_start = to_coord(y0);
         item.x_end = to_coord(x0 + int'($urandom_range(2 * reach)) - reach);
         item.y_end = to_coord(y0 + int'($urandom_range(2 * reach)) - reach);
      end
      dx = $signed(item.x_end) - $signed(item.x_start);
      dy = $signed(item.y_end) - $signed(item.y_start);
      dx = dx < 0 ? -dx : dx;
      dy = dy < 0 ? -dy : dy;
      span_len = dx > dy ? dx : dy;
      return item;
   endfunction

   task automatic send_line(input int xs, input int ys, input int xe, input int ye,
                            input logic [WORD_BITS-1:0] argb, input int steps);
      req_item_type item;
      item = random_item(CMD_START);
      item.x_start = to_coord(xs);
      item.y_start = to_coord(ys);
      item.x_end = to_coord(xe);
      item.y_end = to_coord(ye);
      {item.alpha, item.red, item.green, item.blue} = argb;
      send_req(item);
      repeat (steps) send_req(random_item(CMD_STEP));
   endtask

   // Mostly complete lines with random content; some abandoned part way,
   // some stray steps, a few lines with endpoints anywhere in the range.
   task automatic random_segment(input int quota);
      int done, kind, span_len, steps, cap;
      done = 0;
      while (done < quota) begin
         kind = $urandom_range(99);
         if (kind < 8) begin
            if (sb.line_active) done++;
            send_req(random_item(CMD_STEP));
         end else begin
            send_req(line_start(kind >= 93, span_len));
            done++;
            cap = span_len < MAX_WALK ? span_len : MAX_WALK;
            if (kind < 20) begin
               steps = $urandom_range(cap);
            end else if (span_len + 1 > MAX_WALK) begin
               steps = $urandom_range(1, MAX_WALK);
            end else begin
               steps = span_len + 1;
            end
            repeat (steps) send_req(random_item(CMD_STEP));
            done += steps;
         end
      end
   endtask

   initial begin
      logic [DIM_BITS-1:0] seg_width[6];
      logic [DIM_BITS-1:0] seg_height[6];
      reset = 1'b1;
      req_bus.valid = 1'b0;
      {req_bus.cmd, req_bus.x_start, req_bus.y_start, req_bus.x_end, req_bus.y_end,
       req_bus.red, req_bus.green, req_bus.blue, req_bus.alpha} = '0;
      csr_bus.valid = 1'b0;
      csr_bus.reg_index = REG_SCREEN_WIDTH;
      csr_bus.wdata = '0;

      // Screen sizes per segment: largest nominal, smallest, zero and all-ones
      // (empty screens), then two random picks.
      seg_width = '{12'd2048, 12'd1, 12'd0, 12'd4095, 12'd0, 12'd0};
      seg_height = '{12'd2048, 12'd1, 12'd4095, 12'd0, 12'd0, 12'd0};
      seg_width[4] = DIM_BITS'($urandom_range(1, 2048));
      seg_height[4] = DIM_BITS'($urandom_range(1, 2048));
      seg_width[5] = DIM_BITS'($urandom_range(4095));
      seg_height[5] = DIM_BITS'($urandom_range(4095));

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      req_idle_pct = 16;
      rsp_idle_pct = 82;

      // Directed lines on the reset 640 x 480 screen
      // zero length: one pixel, flagged last
      send_line(0, 0, 0, 0, 32'hFF00_FF00, 1);
      // a full-width row and a full-height column at the coordinate extremes, abandoned after two pixels
      send_line(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN, 32'h00FF_00FF, 2);
      send_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, 32'hFFFF_FFFF, 2);
      // steep, y major forward with the minor axis walking back
      send_line(3, 0, 1, 4, 32'h8040_2010, 5);
      // shallow, x major backward
      send_line(5, 2, 2, 1, 32'h0000_0000, 4);
      // step after the line ended: ignored
      send_req(random_item(CMD_STEP));
      // diagonal tie across the bottom-right corner of the screen
      send_line(638, 478, 641, 481, 32'h0102_0408, 4);

      for (int seg = 0; seg < 6; seg++) begin
         drain_pixels();
         write_csr(REG_SCREEN_WIDTH, seg_width[seg]);
         write_csr(REG_SCREEN_HEIGHT, seg_height[seg]);
         case (seg / 2)
            0: begin
               req_idle_pct = 16;
               rsp_idle_pct = 82;
            end
            1: begin
               req_idle_pct = 82;
               rsp_idle_pct = 16;
            end
            default: begin
               req_idle_pct = 0;
               rsp_idle_pct = 0;
            end
         endcase
         // long receiver hold-off while requests keep coming: the result
         // register fills and req_bus.ready must drop
         if (seg == 4) rsp_hold_left = HOLD_OFF_CYCLES;
         random_segment(SEGMENT_ITEMS);
      end

      drain_pixels();
      if (sb.errors == 0) begin
         $display("fixed_point_line_rasterizer_unit regression: pass");
      end else begin
         $display("fixed_point_line_rasterizer_unit regression: fail");
      end
      $finish;
   end

endmodule
